// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

// ----- src/arb_pkg.sv -----
// ----------------------------------------------------------------------------
// arb_pkg
// shared widths, register codes, stage numbers and types of the affine
// rectangle bounding box pipeline
// ----------------------------------------------------------------------------
package arb_pkg;

   localparam int COORD_W = 32;
   localparam int COEF_W = 32;
   localparam int SIZE_W = 31;
   localparam int PIX_W = 24;

   localparam int COORD_FRAC_BITS_DEF = 8;
   localparam int COEF_FRAC_BITS_DEF = 16;

   localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
   localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
   localparam logic [PIX_W-1:0] PIX_MAX = 24'h7f_ffff;
   localparam logic [PIX_W-1:0] PIX_MIN = 24'h80_0000;

   // pipeline stages
   localparam int NUM_STAGES = 7;
   localparam int STG_CORNER = 0;
   localparam int STG_MUL = 1;
   localparam int STG_ROUND = 2;
   localparam int STG_OFFSET = 3;
   localparam int STG_MINMAX = 4;
   localparam int STG_BOX = 5;
   localparam int STG_PIXEL = 6;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_XX = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_XY = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_X_OFFSET = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_YX = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_COEF_YY = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COEF_Y_OFFSET = 3'd5;

   localparam logic [COEF_W-1:0] COEF_ONE = 32'h0001_0000;
   localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;

   typedef struct packed {
      logic [COEF_W-1:0] xx;
      logic [COEF_W-1:0] xy;
      logic [COEF_W-1:0] x_offset;
      logic [COEF_W-1:0] yx;
      logic [COEF_W-1:0] yy;
      logic [COEF_W-1:0] y_offset;
   } coef_type;

   // per-stage load strobes from the pipeline control
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctl_type;

endpackage

// ----- src/arb_csr.sv -----
// ----------------------------------------------------------------------------
// arb_csr
// matrix coefficient registers behind the configuration port
// ----------------------------------------------------------------------------
module arb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [arb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [arb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [arb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output arb_pkg::coef_type                 coef
);

   arb_pkg::coef_type coef_ff;
   arb_pkg::coef_type coef_in;
   logic [arb_pkg::REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign reg_idx = csr_paddr[arb_pkg::CSR_ADDR_W-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (reg_idx)
            arb_pkg::REG_COEF_XX: coef_in.xx = csr_pwdata;
            arb_pkg::REG_COEF_XY: coef_in.xy = csr_pwdata;
            arb_pkg::REG_COEF_X_OFFSET: coef_in.x_offset = csr_pwdata;
            arb_pkg::REG_COEF_YX: coef_in.yx = csr_pwdata;
            arb_pkg::REG_COEF_YY: coef_in.yy = csr_pwdata;
            arb_pkg::REG_COEF_Y_OFFSET: coef_in.y_offset = csr_pwdata;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.xx <= arb_pkg::COEF_ONE;
         coef_ff.xy <= arb_pkg::COEF_ZERO;
         coef_ff.x_offset <= arb_pkg::COEF_ZERO;
         coef_ff.yx <= arb_pkg::COEF_ZERO;
         coef_ff.yy <= arb_pkg::COEF_ONE;
         coef_ff.y_offset <= arb_pkg::COEF_ZERO;
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         arb_pkg::REG_COEF_XX: csr_prdata = coef_ff.xx;
         arb_pkg::REG_COEF_XY: csr_prdata = coef_ff.xy;
         arb_pkg::REG_COEF_X_OFFSET: csr_prdata = coef_ff.x_offset;
         arb_pkg::REG_COEF_YX: csr_prdata = coef_ff.yx;
         arb_pkg::REG_COEF_YY: csr_prdata = coef_ff.yy;
         arb_pkg::REG_COEF_Y_OFFSET: csr_prdata = coef_ff.y_offset;
         default: csr_prdata = '0;
      endcase
   end

   assign coef = coef_ff;

endmodule

// ----- src/arb_corner.sv -----
// ----------------------------------------------------------------------------
// arb_corner
// near and far edge of one axis: base and base plus extent, saturated
// ----------------------------------------------------------------------------
module arb_corner (
   input  logic                                clock,
   input  arb_pkg::pipe_ctl_type               ctl,
   input  logic signed [arb_pkg::COORD_W-1:0]  base,
   input  logic signed [arb_pkg::COORD_W-1:0]  extent,
   output logic signed [arb_pkg::COORD_W-1:0]  pos [2],
   output logic                                ovf
);

   localparam int EXT_W = arb_pkg::COORD_W + 1;

   logic signed [EXT_W-1:0] far_sum;
   logic signed [arb_pkg::COORD_W-1:0] far_in;
   logic far_sat;
   logic signed [arb_pkg::COORD_W-1:0] near_ff;
   logic signed [arb_pkg::COORD_W-1:0] far_ff;
   logic ovf_ff;

   always_comb begin
      far_sum = EXT_W'(base) + EXT_W'(extent);
      far_sat = far_sum[EXT_W-1] != far_sum[EXT_W-2];
      if (!far_sat) begin
         far_in = far_sum[arb_pkg::COORD_W-1:0];
      end else if (far_sum[EXT_W-1]) begin
         far_in = arb_pkg::COORD_MIN;
      end else begin
         far_in = arb_pkg::COORD_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_CORNER]) begin
         near_ff <= base;
         far_ff <= far_in;
         ovf_ff <= far_sat;
      end
   end

   assign pos[0] = near_ff;
   assign pos[1] = far_ff;
   assign ovf = ovf_ff;

endmodule

// ----- src/arb_map.sv -----
// ----------------------------------------------------------------------------
// arb_map
// one output axis of the affine map for all four corners: multiply,
// round to coordinate precision, add translation and saturate
// ----------------------------------------------------------------------------
module arb_map #(
   parameter int COEF_FRAC_BITS = arb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  arb_pkg::pipe_ctl_type               ctl,
   input  logic signed [arb_pkg::COEF_W-1:0]   coef_a,
   input  logic signed [arb_pkg::COEF_W-1:0]   coef_b,
   input  logic signed [arb_pkg::COORD_W-1:0]  offset,
   input  logic signed [arb_pkg::COORD_W-1:0]  pos_a [2],
   input  logic signed [arb_pkg::COORD_W-1:0]  pos_b [2],
   input  logic                                ovf_in,
   output logic signed [arb_pkg::COORD_W-1:0]  coord [4],
   output logic                                ovf
);

   localparam int PROD_W = arb_pkg::COEF_W + arb_pkg::COORD_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int RND_W = SUM_W - COEF_FRAC_BITS;
   localparam int OFS_W = RND_W + 1;
   localparam int TOP_W = OFS_W - arb_pkg::COORD_W + 1;
   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (COEF_FRAC_BITS - 1));

   // multiply stage
   logic signed [PROD_W-1:0] prod_a_ff [2];
   logic signed [PROD_W-1:0] prod_b_ff [2];
   logic ovf_mul_ff;

   // round stage
   logic signed [SUM_W-1:0] psum [4];
   logic signed [RND_W-1:0] rnd_ff [4];
   logic ovf_rnd_ff;

   // translation stage
   logic signed [OFS_W-1:0] ofs_sum [4];
   logic [TOP_W-1:0] ofs_top [4];
   logic signed [arb_pkg::COORD_W-1:0] coord_in [4];
   logic [3:0] sat_hit;
   logic signed [arb_pkg::COORD_W-1:0] coord_ff [4];
   logic ovf_ofs_ff;

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_MUL]) begin
         for (int i = 0; i < 2; i++) begin
            prod_a_ff[i] <= coef_a * pos_a[i];
            prod_b_ff[i] <= coef_b * pos_b[i];
         end
         ovf_mul_ff <= ovf_in;
      end
   end

   // corner k pairs a-edge k/2 with b-edge k%2
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         psum[k] = SUM_W'(prod_a_ff[k / 2]) + SUM_W'(prod_b_ff[k % 2]) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_ROUND]) begin
         for (int k = 0; k < 4; k++) begin
            rnd_ff[k] <= psum[k][SUM_W-1:COEF_FRAC_BITS];
         end
         ovf_rnd_ff <= ovf_mul_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ofs_sum[k] = OFS_W'(rnd_ff[k]) + OFS_W'(offset);
         ofs_top[k] = ofs_sum[k][OFS_W-1:arb_pkg::COORD_W-1];
         // fits when every bit above the sign matches it
         sat_hit[k] = !((&ofs_top[k]) || !(|ofs_top[k]));
         if (!sat_hit[k]) begin
            coord_in[k] = ofs_sum[k][arb_pkg::COORD_W-1:0];
         end else if (ofs_sum[k][OFS_W-1]) begin
            coord_in[k] = arb_pkg::COORD_MIN;
         end else begin
            coord_in[k] = arb_pkg::COORD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_OFFSET]) begin
         for (int k = 0; k < 4; k++) begin
            coord_ff[k] <= coord_in[k];
         end
         ovf_ofs_ff <= ovf_rnd_ff || (|sat_hit);
      end
   end

   assign coord = coord_ff;
   assign ovf = ovf_ofs_ff;

endmodule

// ----- src/arb_bound.sv -----
// ----------------------------------------------------------------------------
// arb_bound
// extent of one axis over the mapped corners: min and max, box size,
// floored and ceiled pixel edges, pixel size
// ----------------------------------------------------------------------------
module arb_bound #(
   parameter int COORD_FRAC_BITS = arb_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  arb_pkg::pipe_ctl_type               ctl,
   input  logic signed [arb_pkg::COORD_W-1:0]  coord [4],
   input  logic                                ovf_in,
   output logic signed [arb_pkg::COORD_W-1:0]  box_min,
   output logic [arb_pkg::SIZE_W-1:0]          box_size,
   output logic signed [arb_pkg::PIX_W-1:0]    pix_min,
   output logic [arb_pkg::PIX_W-1:0]           pix_size,
   output logic                                ovf
);

   localparam int EXT_W = arb_pkg::COORD_W + 1;
   localparam int DIFF_W = EXT_W + 1;
   localparam int PTOP_W = EXT_W - arb_pkg::PIX_W + 1;
   localparam logic signed [EXT_W-1:0] CEIL_ADD = EXT_W'(2 ** COORD_FRAC_BITS - 1);

   // min / max stage
   logic signed [arb_pkg::COORD_W-1:0] lo01, lo23, hi01, hi23;
   logic signed [arb_pkg::COORD_W-1:0] min_ff, max_ff;
   logic ovf_mm_ff;

   // box stage
   logic signed [EXT_W-1:0] span;
   logic span_sat;
   logic [arb_pkg::SIZE_W-1:0] size_in;
   logic signed [EXT_W-1:0] pl_full;
   logic [PTOP_W-1:0] pl_top;
   logic pl_sat;
   logic signed [arb_pkg::PIX_W-1:0] pl_in;
   logic signed [EXT_W-1:0] pr_full;
   logic signed [arb_pkg::COORD_W-1:0] min_box_ff;
   logic [arb_pkg::SIZE_W-1:0] size_box_ff;
   logic signed [arb_pkg::PIX_W-1:0] pl_ff;
   logic signed [EXT_W-1:0] pr_ff;
   logic ovf_box_ff;

   // pixel stage
   logic signed [DIFF_W-1:0] pw_full;
   logic pw_neg, pw_big;
   logic [arb_pkg::PIX_W-1:0] pw_in;
   logic signed [arb_pkg::COORD_W-1:0] box_min_ff;
   logic [arb_pkg::SIZE_W-1:0] box_size_ff;
   logic signed [arb_pkg::PIX_W-1:0] pix_min_ff;
   logic [arb_pkg::PIX_W-1:0] pix_size_ff;
   logic ovf_ff;

   always_comb begin
      lo01 = (coord[0] < coord[1]) ? coord[0] : coord[1];
      lo23 = (coord[2] < coord[3]) ? coord[2] : coord[3];
      hi01 = (coord[0] > coord[1]) ? coord[0] : coord[1];
      hi23 = (coord[2] > coord[3]) ? coord[2] : coord[3];
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_MINMAX]) begin
         min_ff <= (lo01 < lo23) ? lo01 : lo23;
         max_ff <= (hi01 > hi23) ? hi01 : hi23;
         ovf_mm_ff <= ovf_in;
      end
   end

   always_comb begin
      span = EXT_W'(max_ff) - EXT_W'(min_ff);
      span_sat = |span[EXT_W-1:arb_pkg::SIZE_W];
      size_in = span_sat ? {arb_pkg::SIZE_W{1'b1}} : span[arb_pkg::SIZE_W-1:0];

      pl_full = EXT_W'(min_ff) >>> COORD_FRAC_BITS;
      pl_top = pl_full[EXT_W-1:arb_pkg::PIX_W-1];
      pl_sat = !((&pl_top) || !(|pl_top));
      if (!pl_sat) begin
         pl_in = pl_full[arb_pkg::PIX_W-1:0];
      end else if (pl_full[EXT_W-1]) begin
         pl_in = arb_pkg::PIX_MIN;
      end else begin
         pl_in = arb_pkg::PIX_MAX;
      end

      // ceil of the exact right or bottom edge
      pr_full = (EXT_W'(max_ff) + CEIL_ADD) >>> COORD_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_BOX]) begin
         min_box_ff <= min_ff;
         size_box_ff <= size_in;
         pl_ff <= pl_in;
         pr_ff <= pr_full;
         ovf_box_ff <= ovf_mm_ff || span_sat || pl_sat;
      end
   end

   // width is taken from the saturated pixel edge
   always_comb begin
      pw_full = DIFF_W'(pr_ff) - DIFF_W'(pl_ff);
      pw_neg = pw_full[DIFF_W-1];
      pw_big = |pw_full[DIFF_W-2:arb_pkg::PIX_W];
      if (pw_neg) begin
         pw_in = '0;
      end else if (pw_big) begin
         pw_in = {arb_pkg::PIX_W{1'b1}};
      end else begin
         pw_in = pw_full[arb_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[arb_pkg::STG_PIXEL]) begin
         box_min_ff <= min_box_ff;
         box_size_ff <= size_box_ff;
         pix_min_ff <= pl_ff;
         pix_size_ff <= pw_in;
         ovf_ff <= ovf_box_ff || pw_neg || pw_big;
      end
   end

   assign box_min = box_min_ff;
   assign box_size = box_size_ff;
   assign pix_min = pix_min_ff;
   assign pix_size = pix_size_ff;
   assign ovf = ovf_ff;

endmodule

// ----- src/affine_rect_bounding_box.sv -----
// ----------------------------------------------------------------------------
// affine_rect_bounding_box
// maps the corners of an axis-aligned rectangle through a 2x3 affine matrix
// and returns the bounding box of the result and its enclosing pixel rect
//
//   channel  direction  transfer when          payload
//   req      in         req_valid & req_ready  rect left, top, width, height
//   rsp      out        rsp_valid & rsp_ready  box, pixel rect, overflow
//   csr      in/out     psel & penable         six matrix coefficients
//
// one rectangle per clock sustained while rsp_ready is high; the stages in order:
// corner sums, the eight 32x32 multipliers, rounding add, translation and
// saturation, min/max tree, box and pixel edges, pixel size.
// reset clears the stage valid bits and loads the identity matrix.
// a stalled result holds its stage; earlier stages keep filling any bubbles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_rect_bounding_box #(
   parameter int COORD_FRAC_BITS = arb_pkg::COORD_FRAC_BITS_DEF,
   parameter int COEF_FRAC_BITS = arb_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [arb_pkg::COORD_W-1:0]  req_rect_left,
   input  logic signed [arb_pkg::COORD_W-1:0]  req_rect_top,
   input  logic signed [arb_pkg::COORD_W-1:0]  req_rect_width,
   input  logic signed [arb_pkg::COORD_W-1:0]  req_rect_height,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [arb_pkg::COORD_W-1:0]  rsp_box_left,
   output logic signed [arb_pkg::COORD_W-1:0]  rsp_box_top,
   output logic [arb_pkg::SIZE_W-1:0]          rsp_box_width,
   output logic [arb_pkg::SIZE_W-1:0]          rsp_box_height,
   output logic signed [arb_pkg::PIX_W-1:0]    rsp_pixel_left,
   output logic signed [arb_pkg::PIX_W-1:0]    rsp_pixel_top,
   output logic [arb_pkg::PIX_W-1:0]           rsp_pixel_width,
   output logic [arb_pkg::PIX_W-1:0]           rsp_pixel_height,
   output logic                                rsp_overflow,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [arb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [arb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [arb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int N = arb_pkg::NUM_STAGES;

   arb_pkg::coef_type coef;
   arb_pkg::pipe_ctl_type ctl;

   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] stage_ready;
   logic [N-1:0] src_valid;

   logic signed [arb_pkg::COORD_W-1:0] xs [2];
   logic signed [arb_pkg::COORD_W-1:0] ys [2];
   logic ovf_xs, ovf_ys;
   logic signed [arb_pkg::COORD_W-1:0] map_x [4];
   logic signed [arb_pkg::COORD_W-1:0] map_y [4];
   logic ovf_map_x, ovf_map_y;
   logic ovf_box_x, ovf_box_y;

   arb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // stage control: a stage loads when it is empty or its successor moves on
   always_comb begin
      src_valid = {valid_ff[N-2:0], req_valid};
      stage_ready[N-1] = !valid_ff[N-1] || rsp_ready;
      for (int k = N - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      for (int k = 0; k < N; k++) begin
         ctl.load[k] = stage_ready[k] && src_valid[k];
         valid_in[k] = stage_ready[k] ? src_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[N-1];

   arb_corner u_corner_x (
      .clock  (clock),
      .ctl    (ctl),
      .base   (req_rect_left),
      .extent (req_rect_width),
      .pos    (xs),
      .ovf    (ovf_xs)
   );

   arb_corner u_corner_y (
      .clock  (clock),
      .ctl    (ctl),
      .base   (req_rect_top),
      .extent (req_rect_height),
      .pos    (ys),
      .ovf    (ovf_ys)
   );

   arb_map #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_map_x (
      .clock  (clock),
      .ctl    (ctl),
      .coef_a (coef.xx),
      .coef_b (coef.xy),
      .offset (coef.x_offset),
      .pos_a  (xs),
      .pos_b  (ys),
      .ovf_in (ovf_xs),
      .coord  (map_x),
      .ovf    (ovf_map_x)
   );

   arb_map #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_map_y (
      .clock  (clock),
      .ctl    (ctl),
      .coef_a (coef.yx),
      .coef_b (coef.yy),
      .offset (coef.y_offset),
      .pos_a  (xs),
      .pos_b  (ys),
      .ovf_in (ovf_ys),
      .coord  (map_y),
      .ovf    (ovf_map_y)
   );

   arb_bound #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_bound_x (
      .clock    (clock),
      .ctl      (ctl),
      .coord    (map_x),
      .ovf_in   (ovf_map_x),
      .box_min  (rsp_box_left),
      .box_size (rsp_box_width),
      .pix_min  (rsp_pixel_left),
      .pix_size (rsp_pixel_width),
      .ovf      (ovf_box_x)
   );

   arb_bound #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_bound_y (
      .clock    (clock),
      .ctl      (ctl),
      .coord    (map_y),
      .ovf_in   (ovf_map_y),
      .box_min  (rsp_box_top),
      .box_size (rsp_box_height),
      .pix_min  (rsp_pixel_top),
      .pix_size (rsp_pixel_height),
      .ovf      (ovf_box_y)
   );

   assign rsp_overflow = ovf_box_x || ovf_box_y;

   // input back-pressure only when every stage holds an item
   `ASSERT_AT(a_stall_full, clock, reset, !req_ready |-> (&valid_ff), "req stalled with a bubble in the pipe")
   // a full pipe with a stalled result keeps every item in place
   `ASSERT_NEXT(a_hold_full, clock, reset, (&valid_ff) && !rsp_ready, (&valid_ff), "item lost while stalled")
   // an accepted rectangle lands in the first stage
   `ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, valid_ff[0], "accepted item not captured")

endmodule
